@@ design/spu_pkg.sv @@
// ----------------------------------------------------------------------------
// spu_pkg
// Shared widths, payload types and helpers of the spherical unit vector core.
// ----------------------------------------------------------------------------
package spu_pkg;

   localparam int POS_BITS  = 24;
   localparam int FRAC_BITS = 14;
   localparam int OUT_BITS  = 16;

   // squared magnitudes and their sums
   localparam int SQ_BITS = 2 * POS_BITS;
   // quotient bits of the root search: q = floor(2^(F+1) * sqrt(n/d))
   localparam int QB      = FRAC_BITS + 2;
   localparam int RW      = SQ_BITS + 2 * FRAC_BITS + 2;
   localparam int PW      = SQ_BITS + QB;
   localparam int TW      = SQ_BITS + 2 * QB + 1;
   // rounded term magnitude, at most 2^F
   localparam int MW      = FRAC_BITS + 1;
   localparam int EW      = (MW > OUT_BITS) ? MW : OUT_BITS;

   typedef struct packed {
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] rad_x;
      logic signed [OUT_BITS-1:0] rad_y;
      logic signed [OUT_BITS-1:0] rad_z;
      logic signed [OUT_BITS-1:0] phi_x;
      logic signed [OUT_BITS-1:0] phi_y;
      logic signed [OUT_BITS-1:0] theta_x;
      logic signed [OUT_BITS-1:0] theta_y;
      logic signed [OUT_BITS-1:0] theta_z;
   } rsp_type;

   typedef struct packed {
      logic [SQ_BITS-1:0] xx;
      logic [SQ_BITS-1:0] yy;
      logic [SQ_BITS-1:0] zz;
      logic [SQ_BITS-1:0] rho2;
      logic [SQ_BITS-1:0] r2;
   } sq_type;

   typedef struct packed {
      logic nx;
      logic ny;
      logic nz;
      logic rho_zero;
      logic r_zero;
   } side_type;

   // sign-magnitude to a two's complement output field
   function automatic logic [OUT_BITS-1:0] to_out(input logic [MW-1:0] mag, input logic neg);
      logic [EW-1:0] v;
      v = EW'(mag);
      if (neg) begin
         v = -v;
      end
      return v[OUT_BITS-1:0];
   endfunction

endpackage

@@ design/spherical_unit_vectors_core.sv @@
// ----------------------------------------------------------------------------
// spherical_unit_vectors_core
// Spherical basis vectors (radial, azimuthal, polar) at a 3D position.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_data with a position and raise start; the transfer
//   happens at the clock edge where start is high and busy is low. busy
//   is always low, so a new position may be sent in every cycle.
//   Output: each result appears on rsp_data for one cycle with rsp_valid
//   high; the receiver must take it then, there is no back pressure.
//   Path: the squaring stages, the root lanes and the combine stages
//   lie between the start transfer and the rsp_valid cycle. Throughput: one item
//   per cycle, set by the fully pipelined root lanes (one quotient bit
//   per stage, FRAC_BITS + 2 stages).
//   Results come out in input order, one per item.
//   Reset: synchronous, active high; clears all valid bits so no stray
//   results appear. Nothing else needs clearing.
// ----------------------------------------------------------------------------
module spherical_unit_vectors_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spu_pkg::req_type req_data,
   output logic             rsp_valid,
   output spu_pkg::rsp_type rsp_data
);
   import spu_pkg::*;

   logic     sq_valid;
   sq_type   sq;
   side_type side_sq;

   // sideband travels beside the root lanes
   side_type side_ff  [QB];
   logic     valid_ff [QB];

   logic [MW-1:0] cphi_m, sphi_m, cth_m, sth_m;

   // fully pipelined, never stalls
   assign busy = 1'b0;

   spu_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .req       (req_data),
      .out_valid (sq_valid),
      .sq        (sq),
      .side      (side_sq)
   );

   // cos phi = x/rho, sin phi = y/rho, cos theta = z/r, sin theta = rho/r
   spu_ratio u_cphi (.clock(clock), .num(sq.xx),   .den(sq.rho2), .mag(cphi_m));
   spu_ratio u_sphi (.clock(clock), .num(sq.yy),   .den(sq.rho2), .mag(sphi_m));
   spu_ratio u_cth  (.clock(clock), .num(sq.zz),   .den(sq.r2),   .mag(cth_m));
   spu_ratio u_sth  (.clock(clock), .num(sq.rho2), .den(sq.r2),   .mag(sth_m));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QB; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= sq_valid;
         for (int s = 1; s < QB; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_sq;
      for (int s = 1; s < QB; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   spu_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[QB-1]),
      .side      (side_ff[QB-1]),
      .cphi_m    (cphi_m),
      .sphi_m    (sphi_m),
      .cth_m     (cth_m),
      .sth_m     (sth_m),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/spu_square.sv @@
// ----------------------------------------------------------------------------
// spu_square
// Two stages: coordinate magnitudes squared, then the rho^2 and r^2 sums.
// ----------------------------------------------------------------------------
module spu_square (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  spu_pkg::req_type  req,
   output logic              out_valid,
   output spu_pkg::sq_type   sq,
   output spu_pkg::side_type side
);
   import spu_pkg::*;

   logic [POS_BITS-1:0] px, py, pz;
   logic [POS_BITS-1:0] mx, my, mz;
   logic [SQ_BITS-1:0]  xx_in, yy_in, zz_in;
   logic [SQ_BITS-1:0]  xx_ff, yy_ff, zz_ff;
   logic [2:0]          neg_ff;
   logic                v1_ff, v2_ff;
   sq_type              sq_in, sq_ff;
   side_type            side_in, side_ff;

   always_comb begin
      px = req.pos_x;
      py = req.pos_y;
      pz = req.pos_z;
      mx = px[POS_BITS-1] ? (~px + 1'b1) : px;
      my = py[POS_BITS-1] ? (~py + 1'b1) : py;
      mz = pz[POS_BITS-1] ? (~pz + 1'b1) : pz;
      xx_in = SQ_BITS'(mx) * SQ_BITS'(mx);
      yy_in = SQ_BITS'(my) * SQ_BITS'(my);
      zz_in = SQ_BITS'(mz) * SQ_BITS'(mz);
   end

   always_comb begin
      sq_in.xx   = xx_ff;
      sq_in.yy   = yy_ff;
      sq_in.zz   = zz_ff;
      sq_in.rho2 = xx_ff + yy_ff;
      sq_in.r2   = xx_ff + yy_ff + zz_ff;
      side_in.nx = neg_ff[2];
      side_in.ny = neg_ff[1];
      side_in.nz = neg_ff[0];
      side_in.rho_zero = (sq_in.rho2 == '0);
      side_in.r_zero   = (sq_in.r2 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      zz_ff   <= zz_in;
      neg_ff  <= {px[POS_BITS-1], py[POS_BITS-1], pz[POS_BITS-1]};
      sq_ff   <= sq_in;
      side_ff <= side_in;
   end

   assign out_valid = v2_ff;
   assign sq        = sq_ff;
   assign side      = side_ff;

endmodule

@@ design/spu_ratio.sv @@
// ----------------------------------------------------------------------------
// spu_ratio
// Pipelined root-of-ratio lane: round(2^F * sqrt(num/den)), one bit a stage.
// ----------------------------------------------------------------------------
module spu_ratio (
   input  logic                       clock,
   input  logic [spu_pkg::SQ_BITS-1:0] num,
   input  logic [spu_pkg::SQ_BITS-1:0] den,
   output logic [spu_pkg::MW-1:0]      mag
);
   import spu_pkg::*;

   // residual r = num*2^(2F+2) - q^2*den, running product p = q*den
   logic [RW-1:0]      r_ff [QB];
   logic [RW-1:0]      r_in [QB];
   logic [PW-1:0]      p_ff [QB];
   logic [PW-1:0]      p_in [QB];
   logic [QB-1:0]      q_ff [QB];
   logic [QB-1:0]      q_in [QB];
   logic [SQ_BITS-1:0] d_ff [QB];
   logic [SQ_BITS-1:0] d_in [QB];
   logic [QB:0]        q_inc;

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int B = QB - 1 - s;
      logic [RW-1:0]      r_src;
      logic [PW-1:0]      p_src;
      logic [QB-1:0]      q_src;
      logic [SQ_BITS-1:0] d_src;
      logic [TW-1:0]      trial;
      logic               take;

      if (s == 0) begin : g_first
         assign r_src = RW'(num) << (2 * FRAC_BITS + 2);
         assign p_src = '0;
         assign q_src = '0;
         assign d_src = den;
      end else begin : g_next
         assign r_src = r_ff[s-1];
         assign p_src = p_ff[s-1];
         assign q_src = q_ff[s-1];
         assign d_src = d_ff[s-1];
      end

      // (q + 2^B)^2 d - q^2 d = 2^(B+1) q d + 2^(2B) d
      assign trial = (TW'(p_src) << (B + 1)) + (TW'(d_src) << (2 * B));
      assign take  = (trial <= TW'(r_src));

      assign r_in[s] = take ? (r_src - RW'(trial)) : r_src;
      assign p_in[s] = take ? (p_src + (PW'(d_src) << B)) : p_src;
      assign q_in[s] = take ? (q_src | (QB'(1) << B)) : q_src;
      assign d_in[s] = d_src;

      always_ff @(posedge clock) begin
         r_ff[s] <= r_in[s];
         p_ff[s] <= p_in[s];
         q_ff[s] <= q_in[s];
         d_ff[s] <= d_in[s];
      end
   end

   // round half up: m = floor((q + 1) / 2)
   assign q_inc = {1'b0, q_ff[QB-1]} + 1'b1;
   assign mag   = q_inc[MW:1];

endmodule

@@ design/spu_combine.sv @@
// ----------------------------------------------------------------------------
// spu_combine
// Special cases, rounded products of the angle terms and the result register.
// ----------------------------------------------------------------------------
module spu_combine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  spu_pkg::side_type      side,
   input  logic [spu_pkg::MW-1:0] cphi_m,
   input  logic [spu_pkg::MW-1:0] sphi_m,
   input  logic [spu_pkg::MW-1:0] cth_m,
   input  logic [spu_pkg::MW-1:0] sth_m,
   output logic                   rsp_valid,
   output spu_pkg::rsp_type       rsp_data
);
   import spu_pkg::*;

   localparam int PRW = 2 * MW;

   logic [MW-1:0]  cphi_in, sphi_in, cth_in, sth_in;
   logic [MW-1:0]  cphi_ff, sphi_ff, cth_ff, sth_ff;
   side_type       side_c_ff, side_d_ff;
   logic [PRW-1:0] sc_w, ss_w, cc_w, cs_w;
   logic [MW-1:0]  sc_ff, ss_ff, cc_ff, cs_ff;
   logic [MW-1:0]  cphi_d_ff, sphi_d_ff, cth_d_ff, sth_d_ff;
   logic           vc_ff, vd_ff, ve_ff;
   rsp_type        rsp_in, rsp_ff;

   // origin: all zero; z axis: phi taken as zero
   always_comb begin
      cphi_in = cphi_m;
      sphi_in = sphi_m;
      cth_in  = cth_m;
      sth_in  = sth_m;
      if (side.r_zero) begin
         cphi_in = '0;
         sphi_in = '0;
         cth_in  = '0;
         sth_in  = '0;
      end else if (side.rho_zero) begin
         cphi_in = MW'(1) << FRAC_BITS;
         sphi_in = '0;
      end
   end

   localparam logic [PRW-1:0] HALF = PRW'(1) << (FRAC_BITS - 1);

   assign sc_w = (PRW'(sth_ff) * PRW'(cphi_ff) + HALF) >> FRAC_BITS;
   assign ss_w = (PRW'(sth_ff) * PRW'(sphi_ff) + HALF) >> FRAC_BITS;
   assign cc_w = (PRW'(cth_ff) * PRW'(cphi_ff) + HALF) >> FRAC_BITS;
   assign cs_w = (PRW'(cth_ff) * PRW'(sphi_ff) + HALF) >> FRAC_BITS;

   always_comb begin
      rsp_in.rad_x   = to_out(sc_ff, side_d_ff.nx);
      rsp_in.rad_y   = to_out(ss_ff, side_d_ff.ny);
      rsp_in.rad_z   = to_out(cth_d_ff, side_d_ff.nz);
      rsp_in.phi_x   = to_out(sphi_d_ff, !side_d_ff.ny);
      rsp_in.phi_y   = to_out(cphi_d_ff, side_d_ff.nx);
      rsp_in.theta_x = to_out(cc_ff, !(side_d_ff.nz ^ side_d_ff.nx));
      rsp_in.theta_y = to_out(cs_ff, !(side_d_ff.nz ^ side_d_ff.ny));
      rsp_in.theta_z = to_out(sth_d_ff, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         vc_ff <= in_valid;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      cphi_ff   <= cphi_in;
      sphi_ff   <= sphi_in;
      cth_ff    <= cth_in;
      sth_ff    <= sth_in;
      side_c_ff <= side;
      sc_ff     <= sc_w[MW-1:0];
      ss_ff     <= ss_w[MW-1:0];
      cc_ff     <= cc_w[MW-1:0];
      cs_ff     <= cs_w[MW-1:0];
      cphi_d_ff <= cphi_ff;
      sphi_d_ff <= sphi_ff;
      cth_d_ff  <= cth_ff;
      sth_d_ff  <= sth_ff;
      side_d_ff <= side_c_ff;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = ve_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ verif/spherical_unit_vectors_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_unit_vectors_checker
// Watches position and result transfers, predicts the spherical basis
// vectors for each position and compares them field by field, in order.
// ----------------------------------------------------------------------------
module spherical_unit_vectors_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  spu_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  spu_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import spu_pkg::*;

   rsp_type basis_queue[$];

   // round(2^F * sqrt(n2/d2)), ties up, by bisection on exact integers
   function automatic longint unsigned unit_ratio(longint unsigned n2, longint unsigned d2);
      longint unsigned lo, hi, mid, k;
      logic [191:0] lhs, rhs;
      lo = 0;
      hi = 64'd1 << FRAC_BITS;
      rhs = 192'(n2) << (2 * FRAC_BITS + 2);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         k = 2 * mid - 1;
         lhs = 192'(k * k) * 192'(d2);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint round_mul(longint a, longint b);
      longint unsigned ma, mb, m;
      logic neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic rsp_type basis_at(req_type p);
      longint mx, my, mz;
      longint unsigned xx, yy, zz, rho2, r2;
      longint cphi, sphi, cth, sth;
      rsp_type b;
      mx = p.pos_x; my = p.pos_y; mz = p.pos_z;
      if (mx < 0) mx = -mx;
      if (my < 0) my = -my;
      if (mz < 0) mz = -mz;
      xx = mx * mx; yy = my * my; zz = mz * mz;
      rho2 = xx + yy; r2 = rho2 + zz;
      cphi = 0; sphi = 0; cth = 0; sth = 0;
      if (r2 != 0) begin
         if (rho2 == 0) begin
            cphi = 64'd1 << FRAC_BITS;
         end else begin
            cphi = unit_ratio(xx, rho2);
            sphi = unit_ratio(yy, rho2);
            if (p.pos_x < 0) cphi = -cphi;
            if (p.pos_y < 0) sphi = -sphi;
         end
         cth = unit_ratio(zz, r2);
         if (p.pos_z < 0) cth = -cth;
         sth = unit_ratio(rho2, r2);
      end
      b.rad_x   = OUT_BITS'(round_mul(sth, cphi));
      b.rad_y   = OUT_BITS'(round_mul(sth, sphi));
      b.rad_z   = OUT_BITS'(cth);
      b.phi_x   = OUT_BITS'(-sphi);
      b.phi_y   = OUT_BITS'(cphi);
      b.theta_x = OUT_BITS'(-round_mul(cth, cphi));
      b.theta_y = OUT_BITS'(-round_mul(cth, sphi));
      b.theta_z = OUT_BITS'(sth);
      return b;
   endfunction

   task automatic check_field(string name, logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending = basis_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) basis_queue.push_back(basis_at(req_data));
         if (rsp_valid) begin
            if (basis_queue.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               want = basis_queue.pop_front();
               check_field("rad_x", want.rad_x, rsp_data.rad_x);
               check_field("rad_y", want.rad_y, rsp_data.rad_y);
               check_field("rad_z", want.rad_z, rsp_data.rad_z);
               check_field("phi_x", want.phi_x, rsp_data.phi_x);
               check_field("phi_y", want.phi_y, rsp_data.phi_y);
               check_field("theta_x", want.theta_x, rsp_data.theta_x);
               check_field("theta_y", want.theta_y, rsp_data.theta_y);
               check_field("theta_z", want.theta_z, rsp_data.theta_z);
            end
         end
      end
   end

endmodule

@@ verif/spherical_unit_vectors_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_unit_vectors_core_test
// Drives directed and random positions in bursts into the core; the checker
// beside it predicts and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module spherical_unit_vectors_core_test;
   import spu_pkg::*;

   localparam int LATENCY     = 2 + FRAC_BITS + 2 + 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 2000;

   localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;

   always #5 clock = ~clock;

   spherical_unit_vectors_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   spherical_unit_vectors_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Timeout watchdog: budget covers every item at its longest gap plus latency.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Random coordinate: half full range, else tiny, zero, small or at the rails
   // so that near-axis and rounding-tie cases show up.
   function automatic logic signed [POS_BITS-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return POS_BITS'($signed($urandom_range(0, 6)) - 3);
         1: return $urandom_range(0, 1) ? PMAX : PMIN;
         2: return '0;
         3: return POS_BITS'($signed($urandom_range(0, 2000)) - 1000);
         default: return POS_BITS'($urandom);
      endcase
   endfunction

   // One position transfer; start stays high across back-to-back items
   // and drops only when a gap begins.
   task automatic send_position(req_type p);
      req_data <= p;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   req_type directed_list[$];
   int      burst_left;

   initial begin
      req_type p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: origin, axes both ways, extremes, diagonals
      directed_list = '{
         '{pos_x: 0, pos_y: 0, pos_z: 0},
         '{pos_x: 0, pos_y: 0, pos_z: 1},
         '{pos_x: 0, pos_y: 0, pos_z: -1},
         '{pos_x: 0, pos_y: 0, pos_z: PMIN},
         '{pos_x: 0, pos_y: 0, pos_z: PMAX},
         '{pos_x: 1, pos_y: 0, pos_z: 0},
         '{pos_x: -1, pos_y: 0, pos_z: 0},
         '{pos_x: 0, pos_y: 1, pos_z: 0},
         '{pos_x: 0, pos_y: -1, pos_z: 0},
         '{pos_x: PMIN, pos_y: PMIN, pos_z: PMIN},
         '{pos_x: PMAX, pos_y: PMAX, pos_z: PMAX},
         '{pos_x: PMIN, pos_y: PMAX, pos_z: 0},
         '{pos_x: PMAX, pos_y: 0, pos_z: PMIN},
         '{pos_x: 1, pos_y: 1, pos_z: 1},
         '{pos_x: -1, pos_y: -1, pos_z: -1},
         '{pos_x: 3, pos_y: 4, pos_z: 12},
         '{pos_x: -3, pos_y: 4, pos_z: -12},
         '{pos_x: 1, pos_y: PMAX, pos_z: 1},
         '{pos_x: PMIN, pos_y: 1, pos_z: -1},
         '{pos_x: 1, pos_y: 1, pos_z: PMIN}
      };
      foreach (directed_list[i])
         send_position(directed_list[i]);

      // random bursts with random gaps; some long unbroken stretches
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 10);
         end
         p.pos_x = pick_coord();
         p.pos_y = pick_coord();
         p.pos_z = pick_coord();
         burst_left--;
         send_position(p);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/spu_pkg.sv
design/spu_square.sv
design/spu_ratio.sv
design/spu_combine.sv
design/spherical_unit_vectors_core.sv
verif/spherical_unit_vectors_checker.sv
verif/spherical_unit_vectors_core_test.sv
